### hdl/mas_pkg.sv
// shared types and constants for the moving-average source reweighting block
// no dependencies; imported by mas_ctrl, mas_dp and the top level
`default_nettype none

package mas_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 30;
  localparam int FRAC_W    = 16;
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 24;
  localparam int COLS_W    = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int NS_CFG_W   = 10;
  localparam int LB_CFG_W   = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SOURCES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOK_BACK   = 1'b1;

  localparam logic [NS_CFG_W-1:0] NS_RESET = 10'd512;
  localparam logic [LB_CFG_W-1:0] LB_RESET = 7'd8;
  localparam logic [COLS_W-1:0]   COLS_MAX = 7'd127;

  localparam logic [SAMPLE_W-1:0] SAT_POS     = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG_MAG = 24'h80_0000;
  localparam logic [2*SAMPLE_W-1:0] ROUND_HALF = 48'd32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_record;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] corrected;
    logic                       column_end;
    logic                       passed_through;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic mx_clr;
    logic div_mean;
    logic div_weight;
    logic wr_mean;
    logic wr_weight;
    logic rs_zero;
    logic pass;
    logic mul;
    logic upd;
    logic last;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mx_zero;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/mas_div.sv
// restoring divider, one quotient bit per cycle
// standalone; used by mas_dp for means and normalized weights
`default_nettype none

module mas_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 24,
  localparam int CNT_W = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

### hdl/mas_ctrl.sv
// sequencer: configuration registers, column/record counters and the state machine
// depends on mas_pkg; drives mas_dp through ctrl_cmd_t
`default_nettype none

module mas_ctrl #(
  parameter int MAX_SOURCES   = 512,
  parameter int MAX_LOOK_BACK = 64,
  localparam int POS_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1,
  localparam int NS_W   = $clog2(MAX_SOURCES + 1),
  localparam int SLOT_W = (MAX_LOOK_BACK > 1) ? $clog2(MAX_LOOK_BACK) : 1,
  localparam int LB_W   = $clog2(MAX_LOOK_BACK + 1),
  localparam int ADDR_W = (MAX_SOURCES * MAX_LOOK_BACK > 1) ?
                          $clog2(MAX_SOURCES * MAX_LOOK_BACK) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_sor,
  output logic                          in_ready,
  input  logic                          cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mas_pkg::CFG_DATA_W-1:0] cfg_data,
  output mas_pkg::ctrl_cmd_t            cmd,
  input  mas_pkg::dp_stat_t             stat,
  output logic [POS_W-1:0]              src_addr,
  output logic [ADDR_W-1:0]             win_addr,
  output logic [LB_W-1:0]               lb_eff
);

  import mas_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SETUP   = 4'd1;
  localparam logic [3:0] ST_W1_RD   = 4'd2;
  localparam logic [3:0] ST_W1_GO   = 4'd3;
  localparam logic [3:0] ST_W1_WAIT = 4'd4;
  localparam logic [3:0] ST_W1_WR   = 4'd5;
  localparam logic [3:0] ST_W1_CHK  = 4'd6;
  localparam logic [3:0] ST_W2_RD   = 4'd7;
  localparam logic [3:0] ST_W2_GO   = 4'd8;
  localparam logic [3:0] ST_W2_WAIT = 4'd9;
  localparam logic [3:0] ST_W2_WR   = 4'd10;
  localparam logic [3:0] ST_S_RD    = 4'd11;
  localparam logic [3:0] ST_S_MUL   = 4'd12;
  localparam logic [3:0] ST_S_UPD   = 4'd13;
  localparam logic [3:0] ST_S_OUT   = 4'd14;

  logic [3:0]          state_r, state_nxt;
  logic [NS_CFG_W-1:0] num_sources_r;
  logic [LB_CFG_W-1:0] look_back_r;
  logic [COLS_W-1:0]   cols_r, cols_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [NS_W-1:0]     fill_r, fill_nxt;
  logic [POS_W-1:0]    k_r, k_nxt;
  logic                pass_r, pass_nxt;

  logic [NS_W-1:0] ns_eff;
  logic [NS_W-1:0] pos_inc;
  logic            pos_last;
  logic            k_last;
  logic            slot_wrap;
  logic            pass_now;
  logic            wt_phase;

  always_comb begin
    if (num_sources_r == '0) begin
      ns_eff = NS_W'(1);
    end else if (32'(num_sources_r) > 32'(MAX_SOURCES)) begin
      ns_eff = NS_W'(MAX_SOURCES);
    end else begin
      ns_eff = NS_W'(num_sources_r);
    end
    if (look_back_r == '0) begin
      lb_eff = LB_W'(1);
    end else if (32'(look_back_r) > 32'(MAX_LOOK_BACK)) begin
      lb_eff = LB_W'(MAX_LOOK_BACK);
    end else begin
      lb_eff = LB_W'(look_back_r);
    end
  end

  assign pos_inc   = NS_W'(pos_r) + NS_W'(1);
  assign pos_last  = pos_inc >= ns_eff;
  assign k_last    = (NS_W'(k_r) + NS_W'(1)) >= ns_eff;
  assign slot_wrap = (LB_W'(slot_r) + LB_W'(1)) >= lb_eff;
  assign pass_now  = 32'(cols_r) < 32'(lb_eff);

  assign wt_phase = (state_r == ST_W1_RD) || (state_r == ST_W1_GO) ||
                    (state_r == ST_W1_WAIT) || (state_r == ST_W1_WR) ||
                    (state_r == ST_W1_CHK) || (state_r == ST_W2_RD) ||
                    (state_r == ST_W2_GO) || (state_r == ST_W2_WAIT) ||
                    (state_r == ST_W2_WR);

  assign src_addr = wt_phase ? k_r : pos_r;
  assign win_addr = ADDR_W'(slot_r) * ADDR_W'(MAX_SOURCES) + ADDR_W'(pos_r);

  always_comb begin
    state_nxt = state_r;
    cols_nxt  = cols_r;
    pos_nxt   = pos_r;
    slot_nxt  = slot_r;
    fill_nxt  = fill_r;
    k_nxt     = k_r;
    pass_nxt  = pass_r;
    in_ready  = 1'b0;
    cmd       = '0;
    // running sum entries past the fill mark were never written in this record
    cmd.rs_zero = NS_W'(src_addr) >= fill_r;
    cmd.pass    = pass_r;
    cmd.last    = pos_last;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
          if (in_sor) begin
            cols_nxt = '0;
            pos_nxt  = '0;
            slot_nxt = '0;
            fill_nxt = '0;
          end
        end
      end
      ST_SETUP: begin
        pass_nxt = pass_now;
        if (!pass_now && pos_r == '0) begin
          cmd.mx_clr = 1'b1;
          k_nxt      = '0;
          state_nxt  = ST_W1_RD;
        end else begin
          state_nxt = ST_S_RD;
        end
      end
      ST_W1_RD: state_nxt = ST_W1_GO;
      ST_W1_GO: begin
        cmd.div_mean = 1'b1;
        state_nxt    = ST_W1_WAIT;
      end
      ST_W1_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_W1_WR;
        end
      end
      ST_W1_WR: begin
        cmd.wr_mean = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_W1_CHK;
        end else begin
          k_nxt     = k_r + POS_W'(1);
          state_nxt = ST_W1_RD;
        end
      end
      ST_W1_CHK: begin
        // zero maximum keeps the raw means as weights
        state_nxt = stat.mx_zero ? ST_S_RD : ST_W2_RD;
      end
      ST_W2_RD: state_nxt = ST_W2_GO;
      ST_W2_GO: begin
        cmd.div_weight = 1'b1;
        state_nxt      = ST_W2_WAIT;
      end
      ST_W2_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_W2_WR;
        end
      end
      ST_W2_WR: begin
        cmd.wr_weight = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = ST_S_RD;
        end else begin
          k_nxt     = k_r + POS_W'(1);
          state_nxt = ST_W2_RD;
        end
      end
      ST_S_RD: state_nxt = ST_S_MUL;
      ST_S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_S_UPD;
      end
      ST_S_UPD: begin
        cmd.upd = 1'b1;
        if (pos_inc > fill_r) begin
          fill_nxt = pos_inc;
        end
        if (pos_last) begin
          pos_nxt  = '0;
          slot_nxt = slot_wrap ? '0 : slot_r + SLOT_W'(1);
          if (cols_r != COLS_MAX) begin
            cols_nxt = cols_r + COLS_W'(1);
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
        state_nxt = ST_S_OUT;
      end
      ST_S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_sources_r <= NS_RESET;
      look_back_r   <= LB_RESET;
      cols_r        <= '0;
      pos_r         <= '0;
      slot_r        <= '0;
      fill_r        <= '0;
      k_r           <= '0;
      pass_r        <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cols_r  <= cols_nxt;
      pos_r   <= pos_nxt;
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_SOURCES: num_sources_r <= cfg_data[NS_CFG_W-1:0];
          CFG_LOOK_BACK:   look_back_r   <= cfg_data[LB_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### hdl/mas_dp.sv
// datapath: window, running-sum and weight memories, divider, multiplier, output stage
// depends on mas_pkg and mas_div; commanded by mas_ctrl
`default_nettype none

module mas_dp #(
  parameter int MAX_SOURCES   = 512,
  parameter int MAX_LOOK_BACK = 64,
  localparam int POS_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1,
  localparam int LB_W   = $clog2(MAX_LOOK_BACK + 1),
  localparam int ADDR_W = (MAX_SOURCES * MAX_LOOK_BACK > 1) ?
                          $clog2(MAX_SOURCES * MAX_LOOK_BACK) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mas_pkg::in_word_t  in_word,
  input  mas_pkg::ctrl_cmd_t cmd,
  output mas_pkg::dp_stat_t  stat,
  input  logic [POS_W-1:0]   src_addr,
  input  logic [ADDR_W-1:0]  win_addr,
  input  logic [LB_W-1:0]    lb_eff,
  input  logic               out_ready,
  output logic               out_valid,
  output mas_pkg::out_word_t out_word
);

  import mas_pkg::*;

  localparam int WIN_DEPTH = MAX_SOURCES * MAX_LOOK_BACK;
  localparam int PROD_W    = 2 * SAMPLE_W;

  logic [SUM_W-1:0]    rs_mem  [MAX_SOURCES];
  logic [SAMPLE_W-1:0] wt_mem  [MAX_SOURCES];
  logic [SAMPLE_W-1:0] win_mem [WIN_DEPTH];

  logic [SUM_W-1:0]    rs_q;
  logic [SAMPLE_W-1:0] wt_q;
  logic [SAMPLE_W-1:0] win_q;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [SAMPLE_W-1:0]        mx_r;
  out_word_t                  pend_r;
  out_word_t                  out_word_r;
  logic                       out_valid_r;

  logic [SUM_W-1:0]     rs_eff;
  logic                 rs_neg;
  logic [SUM_W-1:0]     rs_mag;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [SAMPLE_W-1:0]  mean_mag;
  logic [SAMPLE_W-1:0]  mean_val;
  logic [SAMPLE_W-1:0]  wt_mag;

  logic [PROD_W-1:0]   prod_u;
  logic                p_neg;
  logic [PROD_W-1:0]   p_mag;
  logic [PROD_W-1:0]   p_rnd;
  logic [PROD_W-FRAC_W-1:0] p_q;
  logic [SAMPLE_W-1:0] p_sat;
  logic [SAMPLE_W-1:0] res;
  logic [SUM_W-1:0]    win_ext;
  logic [SUM_W-1:0]    res_ext;
  logic [SUM_W-1:0]    sum_nxt;

  // memories: registered read every cycle at the commanded address
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      rs_mem[src_addr] <= sum_nxt;
    end
    rs_q <= rs_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_mean) begin
      wt_mem[src_addr] <= mean_val;
    end else if (cmd.wr_weight) begin
      wt_mem[src_addr] <= div_quo[SAMPLE_W-1:0];
    end
    wt_q <= wt_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      win_mem[win_addr] <= res;
    end
    win_q <= win_mem[win_addr];
  end

  // mean = running sum / look_back, rounded half away from zero
  always_comb begin
    rs_eff   = cmd.rs_zero ? '0 : rs_q;
    rs_neg   = rs_eff[SUM_W-1];
    rs_mag   = rs_neg ? (~rs_eff + SUM_W'(1)) : rs_eff;
    if (rs_neg) begin
      mean_mag = (div_quo > DIV_NUM_W'(SAT_NEG_MAG)) ? SAT_NEG_MAG : div_quo[SAMPLE_W-1:0];
    end else begin
      mean_mag = (div_quo > DIV_NUM_W'(SAT_POS)) ? SAT_POS : div_quo[SAMPLE_W-1:0];
    end
    mean_val = rs_neg ? (~mean_mag + SAMPLE_W'(1)) : mean_mag;
    wt_mag   = wt_q[SAMPLE_W-1] ? (~wt_q + SAMPLE_W'(1)) : wt_q;
    if (cmd.div_weight) begin
      div_num = {wt_mag, {FRAC_W{1'b0}}} + DIV_NUM_W'(mx_r >> 1);
      div_den = mx_r;
    end else begin
      div_num = DIV_NUM_W'(rs_mag) + DIV_NUM_W'(lb_eff >> 1);
      div_den = DIV_DEN_W'(lb_eff);
    end
    div_start = cmd.div_mean | cmd.div_weight;
  end

  mas_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // product scaled back by 2^16, rounded half away from zero, saturated
  always_comb begin
    prod_u = prod_r;
    p_neg  = prod_u[PROD_W-1];
    p_mag  = p_neg ? (~prod_u + PROD_W'(1)) : prod_u;
    p_rnd  = p_mag + ROUND_HALF;
    p_q    = p_rnd[PROD_W-1:FRAC_W];
    if (p_neg) begin
      p_sat = (p_q > (PROD_W-FRAC_W)'(SAT_NEG_MAG)) ? SAT_NEG_MAG : p_q[SAMPLE_W-1:0];
    end else begin
      p_sat = (p_q > (PROD_W-FRAC_W)'(SAT_POS)) ? SAT_POS : p_q[SAMPLE_W-1:0];
    end
    res     = cmd.pass ? sample_r : (p_neg ? (~p_sat + SAMPLE_W'(1)) : p_sat);
    win_ext = cmd.pass ? '0 : {{(SUM_W-SAMPLE_W){win_q[SAMPLE_W-1]}}, win_q};
    res_ext = {{(SUM_W-SAMPLE_W){res[SAMPLE_W-1]}}, res};
    // wraps within the sum width
    sum_nxt = rs_eff - win_ext + res_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_word.sample;
    end
    if (cmd.mul) begin
      prod_r <= sample_r * $signed(wt_q);
    end
    if (cmd.mx_clr) begin
      mx_r <= '0;
    end else if (cmd.wr_mean && mean_mag > mx_r) begin
      mx_r <= mean_mag;
    end
    if (cmd.upd) begin
      pend_r.corrected      <= res;
      pend_r.column_end     <= cmd.last;
      pend_r.passed_through <= cmd.pass;
    end
    if (cmd.out_load) begin
      out_word_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.div_done = div_done;
  assign stat.mx_zero  = (mx_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;

endmodule

`default_nettype wire

### hdl/moving_average_source_reweighting_top.sv
// sequence: an accepted mid-column word goes through setup, read, multiply, update
// and output-load states; in_ready stays low until its result is loaded for output
// first word of each weighted column needs two 40-step divider runs per source
// (mean, then normalized weight unless all means are zero) through one shared divider
// reset: synchronous active-low rst_n clears control state; running sums read as zero
// through a fill count, so no clearing pass follows reset
`default_nettype none

module moving_average_source_reweighting_top #(
  parameter int MAX_SOURCES   = 512,
  parameter int MAX_LOOK_BACK = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mas_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mas_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mas_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mas_pkg::*;

  localparam int POS_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int LB_W   = $clog2(MAX_LOOK_BACK + 1);
  localparam int ADDR_W = (MAX_SOURCES * MAX_LOOK_BACK > 1) ?
                          $clog2(MAX_SOURCES * MAX_LOOK_BACK) : 1;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [POS_W-1:0]  src_addr;
  logic [ADDR_W-1:0] win_addr;
  logic [LB_W-1:0]   lb_eff;

  mas_ctrl #(
    .MAX_SOURCES   (MAX_SOURCES),
    .MAX_LOOK_BACK (MAX_LOOK_BACK)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_sor    (in_word.start_of_record),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .src_addr  (src_addr),
    .win_addr  (win_addr),
    .lb_eff    (lb_eff)
  );

  mas_dp #(
    .MAX_SOURCES   (MAX_SOURCES),
    .MAX_LOOK_BACK (MAX_LOOK_BACK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .src_addr  (src_addr),
    .win_addr  (win_addr),
    .lb_eff    (lb_eff),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
